// ----- design/wtdf_pkg.sv -----
// shared types, constants and the wheel gap table of the trial-division factoriser
`timescale 1ns / 1ps

package wtdf_pkg;

    // lead-in steps 2->3->5->7->11, then the 48 gaps of the mod-210 wheel
    localparam int WHEEL_LEAD   = 4;
    localparam int WHEEL_LENGTH = 48;
    localparam int WHEEL_SPAN   = WHEEL_LEAD + WHEEL_LENGTH;
    localparam int POS_W        = $clog2(WHEEL_SPAN);
    localparam int GAP_W        = 4;

    // results per number; once the last-but-one slot is used, later factors
    // overwrite the final slot
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    localparam logic [GAP_W-1:0] GAP_TABLE [0:WHEEL_SPAN-1] = '{
        4'd1, 4'd2, 4'd2, 4'd4,
        4'd2, 4'd4, 4'd2, 4'd4, 4'd6, 4'd2, 4'd6, 4'd4, 4'd2, 4'd4, 4'd6, 4'd6,
        4'd2, 4'd6, 4'd4, 4'd2, 4'd6, 4'd4, 4'd6, 4'd8,
        4'd4, 4'd2, 4'd4, 4'd2, 4'd4, 4'd8, 4'd6, 4'd4, 4'd6, 4'd2, 4'd4, 4'd6,
        4'd2, 4'd6, 4'd6, 4'd4, 4'd2, 4'd4, 4'd6, 4'd2,
        4'd6, 4'd4, 4'd2, 4'd4, 4'd2, 4'd10, 4'd2, 4'd10
    };

    // what goes into the output register
    typedef enum logic [1:0] {
        SRC_PEND = 2'd0,
        SRC_REM  = 2'd1,
        SRC_ZERO = 2'd2
    } out_src_t;

    // controller to datapath
    typedef struct packed {
        logic     load;        // take a new number, restart at divisor 2
        logic     div_start;   // divide the cofactor by the trial divisor
        logic     take_factor; // divisor divides: hold it, cofactor becomes the quotient
        logic     advance;     // step the divisor along the wheel
        logic     push;        // load the output register
        out_src_t src;
        logic     last;
    } wtdf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic number_zero;  // input word is zero
        logic div_done;     // quotient and remainder ready
        logic rem_zero;     // remainder is zero
        logic d_past_q;     // next divisor exceeds the quotient
        logic n_is_one;     // cofactor is one
        logic n0_one;       // number was one
        logic flush_needed; // a held factor must go out before the next one
        logic can_emit;     // output register free this cycle
    } wtdf_status_t;

endpackage

// ----- design/wtdf_divider.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module wtdf_divider #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [VALUE_WIDTH-1:0] remainder,
    output logic                   done
);

    localparam int W     = VALUE_WIDTH;
    localparam int STEPW = $clog2(W);

    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dvs_reg;
    logic [STEPW-1:0] step_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W:0]   trial;
    logic         ge;
    logic [W:0]   diff;
    logic [W-1:0] rem_next;

    assign trial    = {rem_reg, quo_reg[W-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_next = ge ? diff[W-1:0] : trial[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && step_reg == STEPW'(W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[W-2:0], ge};
            step_reg <= step_reg + STEPW'(1);
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ----- design/wtdf_datapath.sv -----
// datapath: cofactor, trial divisor, wheel position, held factor and output register
`timescale 1ns / 1ps

module wtdf_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  wtdf_pkg::wtdf_cmd_t              cmd,
    output wtdf_pkg::wtdf_status_t           status,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic                             m_tlast
);

    import wtdf_pkg::*;

    localparam int W      = VALUE_WIDTH;
    localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    logic [W-1:0]     n_reg;
    logic [W-1:0]     d_reg;
    logic [W-1:0]     pend_reg;
    logic [POS_W-1:0] pos_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             have_pend_reg;
    logic             n0_one_reg;
    logic             m_tvalid_reg;
    logic             m_tlast_reg;
    logic [W-1:0]     m_data_reg;

    logic [W-1:0]     number;
    logic [W-1:0]     div_quo;
    logic [W-1:0]     div_rem;
    logic             div_done;
    logic [W:0]       d_sum;
    logic [POS_W-1:0] pos_step;
    logic [W-1:0]     out_value;
    logic             can_emit;

    assign number = s_tdata[W-1:0];

    wtdf_divider #(
        .VALUE_WIDTH(W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .quotient (div_quo),
        .remainder(div_rem),
        .done     (div_done)
    );

    assign d_sum    = {1'b0, d_reg} + (W+1)'(GAP_TABLE[pos_reg]);
    assign pos_step = (pos_reg == POS_W'(WHEEL_SPAN - 1)) ? POS_W'(WHEEL_LEAD)
                                                         : pos_reg + POS_W'(1);
    assign can_emit = !m_tvalid_reg || m_tready;

    always_comb
    begin
        case (cmd.src)
            SRC_PEND: out_value = pend_reg;
            SRC_REM:  out_value = n_reg;
            SRC_ZERO: out_value = '0;
            default:  out_value = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg         <= number;
            d_reg         <= W'(2);
            pos_reg       <= '0;
            cnt_reg       <= '0;
            have_pend_reg <= 1'b0;
            n0_one_reg    <= (number == W'(1));
        end
        else
        begin
            if (cmd.take_factor)
            begin
                pend_reg      <= d_reg;
                have_pend_reg <= 1'b1;
                n_reg         <= div_quo;
            end
            if (cmd.advance)
            begin
                d_reg   <= d_sum[W-1:0];
                pos_reg <= pos_step;
            end
            if (cmd.push && !cmd.last)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
        if (cmd.push)
        begin
            m_data_reg  <= out_value;
            m_tlast_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.number_zero  = (number == '0);
    assign status.div_done     = div_done;
    assign status.rem_zero     = (div_rem == '0);
    assign status.d_past_q     = d_sum > {1'b0, div_quo};
    assign status.n_is_one     = (n_reg == W'(1));
    assign status.n0_one       = n0_one_reg;
    assign status.flush_needed = have_pend_reg && (cnt_reg != CNT_W'(MAX_RESULTS - 1));
    assign status.can_emit     = can_emit;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'(m_data_reg);
    assign m_tlast  = m_tlast_reg;

    // a word is never overwritten before the sink has taken it
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> can_emit)
        else $error("output register loaded while still full");

    // a factor is only taken on an exact division
    a_take_exact: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_factor |-> (div_rem == '0) && !cmd.advance)
        else $error("factor taken on a non-zero remainder");

    // the held factor exists whenever the final word comes from it
    a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && cmd.src == SRC_PEND) |-> have_pend_reg)
        else $error("held factor sent while none is held");

endmodule

// ----- design/wtdf_ctrl.sv -----
// controller state machine of the trial-division factoriser
`timescale 1ns / 1ps

module wtdf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  wtdf_pkg::wtdf_status_t status,
    output wtdf_pkg::wtdf_cmd_t    cmd
);

    import wtdf_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_ZERO      = 7'b0000010,
        ST_DIV_START = 7'b0000100,
        ST_DIV_WAIT  = 7'b0001000,
        ST_CHECK     = 7'b0010000,
        ST_FIN       = 7'b0100000,
        ST_LAST_REM  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   emit_rem;

    // the cofactor is a prime of its own unless it dropped to one; an input of one is sent as it is
    assign emit_rem = !status.n_is_one || status.n0_one;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.src    = SRC_PEND;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.number_zero ? ST_ZERO : ST_DIV_START;
                end
            end
            ST_ZERO:
            begin
                if (status.can_emit)
                begin
                    cmd.push   = 1'b1;
                    cmd.src    = SRC_ZERO;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.rem_zero)
                begin
                    if (!status.flush_needed || status.can_emit)
                    begin
                        cmd.push        = status.flush_needed;
                        cmd.take_factor = 1'b1;
                        state_next      = ST_DIV_START;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = status.d_past_q ? ST_FIN : ST_DIV_START;
                end
            end
            ST_FIN:
            begin
                if (emit_rem)
                begin
                    if (!status.flush_needed)
                    begin
                        state_next = ST_LAST_REM;
                    end
                    else if (status.can_emit)
                    begin
                        cmd.push   = 1'b1;
                        state_next = ST_LAST_REM;
                    end
                end
                else if (status.can_emit)
                begin
                    cmd.push   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LAST_REM:
            begin
                if (status.can_emit)
                begin
                    cmd.push   = 1'b1;
                    cmd.src    = SRC_REM;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // at most one command class per cycle
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_start, cmd.take_factor, cmd.advance}))
        else $error("conflicting datapath commands");

    // a division result is first looked at in the cycle after it completes
    a_check_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_CHECK) |-> $past(status.div_done))
        else $error("division result used before it was ready");

    // every new number starts a division or the zero answer next
    a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_DIV_START) || (state_reg == ST_ZERO))
        else $error("load not followed by a division or the zero answer");

endmodule

// ----- design/wheel_trial_division_factorizer_core.sv -----
// top level of the wheel trial-division prime factoriser
`timescale 1ns / 1ps

// Factorises one unsigned number per input word and returns its prime
// factors in ascending order, one per output word, with m_tlast on the final
// one. Trial divisors run 2, 3, 5, 7, 11 and then step along the mod-210 wheel;
// once the next divisor passes the quotient, the cofactor left over (if above
// one) is sent as the largest prime. An input of 1 returns 1, an input of 0
// returns 0. Each trial divisor costs one pass of the shared bit-serial
// divider: start, the VALUE_WIDTH quotient bits, the done flag and the check.
// Every factor found costs one more such pass. So a number takes roughly
// (number of wheel divisors up to sqrt of the largest cofactor + number of
// factors) divider passes. One number is worked at a time; s_tready rises
// again as soon as the last word is loaded into the output register, so the
// next number can start while that word waits on m_tready. A word stalled on
// m_tready also stalls the search. There is no reset-time sweep; the block is
// ready as soon as reset is released.

module wheel_trial_division_factorizer_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,   // number
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_tdata,   // prime_factor
    output logic                             m_tlast    // last factor of the number
);

    import wtdf_pkg::*;

    wtdf_cmd_t    cmd;
    wtdf_status_t status;

    // sequencing: one-hot state machine
    wtdf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    // registers, wheel table, divider and output register
    wtdf_datapath #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // an accepted number always starts from a fresh search
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> cmd.load)
        else $error("input word accepted without a load");

    // the final word of a number clears the way for the next input
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && cmd.last) |=> s_tready)
        else $error("not ready for input after the final factor");

    // outside idle no input word is taken
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start || cmd.advance || cmd.take_factor) |-> !s_tready)
        else $error("input ready during a search");

endmodule
